// ----- hw/rtl/jts_pkg.sv -----
// jts_pkg: shared types, constants and the token-start decode for the JSON token scanner.
// No dependencies; used by every module of the scanner.
`timescale 1ns / 1ps

package jts_pkg;

	// Hard cap on content bytes per token, and the width of the byte counter
	localparam int MAX_TOKEN = 63;
	localparam int CNT_W = 6;
	typedef logic [CNT_W-1:0] count_t;

	// Output queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

	// Configuration port
	localparam int ADDR_W = 3;
	localparam logic REG_MAX_CHARS = 1'b0;
	localparam count_t MAX_CHARS_RST = count_t'(63);

	// Characters with a special meaning
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_DIGIT9 = 8'h39;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_STR  = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_INT  = 3'd3,
		MODE_FRAC = 3'd4,
		MODE_ERR  = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		KIND_LBRACE = 4'd0,
		KIND_RBRACE = 4'd1,
		KIND_LBRACK = 4'd2,
		KIND_RBRACK = 4'd3,
		KIND_COLON  = 4'd4,
		KIND_COMMA  = 4'd5,
		KIND_STRING = 4'd6,
		KIND_NUMBER = 4'd7,
		KIND_END    = 4'd8,
		KIND_ERROR  = 4'd9,
		KIND_CHAR   = 4'd10
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_value;
		logic        last;
	} result_t;

	// Results of one byte: how many (0..2) and the two slots
	typedef struct packed {
		logic [1:0]  count;
		result_t     r0;
		result_t     r1;
	} scan_out_t;

	// Decode of a byte that opens a new token
	typedef struct packed {
		logic        emit;
		kind_t       kind;
		mode_t       mode;
		logic        clr_count;
		logic        set_one;
	} start_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
	endfunction

	function automatic start_t start_token(input logic [7:0] b);
		start_t st;
		st.emit = 1'b1;
		st.kind = KIND_ERROR;
		st.mode = MODE_IDLE;
		st.clr_count = 1'b0;
		st.set_one = 1'b0;
		case (b) inside
			CH_NUL: st.kind = KIND_END;
			CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
				st.emit = 1'b0;
				st.kind = KIND_END;
			end
			CH_LBRACE: st.kind = KIND_LBRACE;
			CH_RBRACE: st.kind = KIND_RBRACE;
			CH_LBRACK: st.kind = KIND_LBRACK;
			CH_RBRACK: st.kind = KIND_RBRACK;
			CH_COLON: st.kind = KIND_COLON;
			CH_COMMA: st.kind = KIND_COMMA;
			CH_QUOTE: begin
				st.emit = 1'b0;
				st.kind = KIND_END;
				st.mode = MODE_STR;
				st.clr_count = 1'b1;
			end
			CH_MINUS, [CH_DIGIT0:CH_DIGIT9]: begin
				st.kind = KIND_CHAR;
				st.mode = MODE_INT;
				st.set_one = 1'b1;
			end
			default: begin
				st.kind = KIND_ERROR;
				st.mode = MODE_ERR;
			end
		endcase
		return st;
	endfunction

endpackage

// ----- hw/rtl/jts_scan.sv -----
// jts_scan: scanner state (mode, byte count) and the per-byte decode into up to two results.
// Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         text_byte,
	input  logic               commit,
	input  jts_pkg::count_t    limit,
	output jts_pkg::scan_out_t res
);

	jts_pkg::mode_t   mode_q, mode_d;
	jts_pkg::count_t  count_q, count_d;
	jts_pkg::start_t  st;
	jts_pkg::kind_t   k0, k1;
	logic [1:0]       n;
	logic             below_lim;

	// Next state and result kinds
	always_comb begin
		st = jts_pkg::start_token(text_byte);
		below_lim = count_q < limit;
		mode_d = mode_q;
		count_d = count_q;
		n = 2'd0;
		k0 = jts_pkg::KIND_END;
		k1 = jts_pkg::KIND_END;
		case (mode_q)
			jts_pkg::MODE_STR: begin
				if (text_byte == jts_pkg::CH_QUOTE) begin
					n = 2'd1;
					k0 = jts_pkg::KIND_STRING;
					mode_d = jts_pkg::MODE_IDLE;
				end else if (text_byte == jts_pkg::CH_NUL) begin
					n = 2'd2;
					k0 = jts_pkg::KIND_ERROR;
					mode_d = jts_pkg::MODE_IDLE;
				end else if (!below_lim) begin
					n = 2'd1;
					k0 = jts_pkg::KIND_ERROR;
					mode_d = jts_pkg::MODE_ERR;
				end else if (text_byte == jts_pkg::CH_BSLASH) begin
					mode_d = jts_pkg::MODE_ESC;
				end else begin
					n = 2'd1;
					k0 = jts_pkg::KIND_CHAR;
					count_d = count_q + jts_pkg::count_t'(1);
				end
			end
			jts_pkg::MODE_ESC: begin
				if (text_byte == jts_pkg::CH_NUL) begin
					n = 2'd2;
					k0 = jts_pkg::KIND_ERROR;
					mode_d = jts_pkg::MODE_IDLE;
				end else begin
					n = 2'd1;
					k0 = jts_pkg::KIND_CHAR;
					count_d = count_q + jts_pkg::count_t'(1);
					mode_d = jts_pkg::MODE_STR;
				end
			end
			jts_pkg::MODE_INT, jts_pkg::MODE_FRAC: begin
				if (below_lim && jts_pkg::is_digit(text_byte)) begin
					n = 2'd1;
					k0 = jts_pkg::KIND_CHAR;
					count_d = count_q + jts_pkg::count_t'(1);
				end else if (below_lim && mode_q == jts_pkg::MODE_INT &&
						text_byte == jts_pkg::CH_DOT) begin
					n = 2'd1;
					k0 = jts_pkg::KIND_CHAR;
					count_d = count_q + jts_pkg::count_t'(1);
					mode_d = jts_pkg::MODE_FRAC;
				end else begin
					// number closes, then the byte opens a new token
					n = st.emit ? 2'd2 : 2'd1;
					k0 = jts_pkg::KIND_NUMBER;
					k1 = st.kind;
					mode_d = st.mode;
					if (st.clr_count) count_d = '0;
					if (st.set_one) count_d = jts_pkg::count_t'(1);
				end
			end
			jts_pkg::MODE_ERR: begin
				if (text_byte == jts_pkg::CH_NUL) begin
					n = 2'd1;
					k0 = jts_pkg::KIND_END;
					mode_d = jts_pkg::MODE_IDLE;
				end
			end
			default: begin
				n = {1'b0, st.emit};
				k0 = st.kind;
				mode_d = st.mode;
				if (st.clr_count) count_d = '0;
				if (st.set_one) count_d = jts_pkg::count_t'(1);
			end
		endcase
	end

	// Pack results; char value only on content bytes, last on the final one
	always_comb begin
		res.count = n;
		res.r0.kind = k0;
		res.r0.char_value = (k0 == jts_pkg::KIND_CHAR) ? text_byte : 8'h00;
		res.r0.last = (n == 2'd1);
		res.r1.kind = k1;
		res.r1.char_value = (k1 == jts_pkg::KIND_CHAR) ? text_byte : 8'h00;
		res.r1.last = (n == 2'd2);
	end

	// State advances only when the byte's results are committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jts_pkg::MODE_IDLE;
			count_q <= '0;
		end else if (commit) begin
			mode_q <= mode_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- hw/rtl/jts_out_fifo.sv -----
// jts_out_fifo: small result queue that takes up to two results per cycle and drives the
// output stream. Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_out_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  jts_pkg::scan_out_t           res,
	output logic [jts_pkg::LVL_W-1:0]    space,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,
	output logic [3:0]                   m_tuser,
	output logic                         m_tlast
);

	jts_pkg::result_t                mem_q [jts_pkg::FIFO_DEPTH];
	logic [jts_pkg::PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [jts_pkg::LVL_W-1:0]       level_q;
	logic [jts_pkg::LVL_W-1:0]       n_in;
	logic                            pop;
	jts_pkg::result_t                head;

	assign n_in = push ? jts_pkg::LVL_W'(res.count) : '0;
	assign pop = m_tvalid && m_tready;
	assign space = jts_pkg::LVL_W'(jts_pkg::FIFO_DEPTH) - level_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push && res.count != 2'd0) mem_q[wr_ptr_q] <= res.r0;
		if (push && res.count == 2'd2) mem_q[wr_ptr_q + jts_pkg::PTR_W'(1)] <= res.r1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_in[jts_pkg::PTR_W-1:0];
			if (pop) rd_ptr_q <= rd_ptr_q + jts_pkg::PTR_W'(1);
			level_q <= level_q + n_in - jts_pkg::LVL_W'(pop);
		end
	end

	// Head of queue drives the stream
	assign head = mem_q[rd_ptr_q];
	assign m_tvalid = level_q != '0;
	assign m_tuser = head.kind;
	assign m_tdata = head.char_value;
	assign m_tlast = head.last;

endmodule

// ----- hw/rtl/json_token_scanner.sv -----
// json_token_scanner: top level of the streaming JSON lexer; input register, config register,
// scanner and result queue. Depends on jts_pkg, jts_scan, jts_out_fifo.
`timescale 1ns / 1ps

// Usage:
//   Text bytes come in on the s_ stream, one byte per request in s_tdata; byte 0 ends
//   the document. Tokens leave on the m_ stream: m_tuser is the token kind, m_tdata the
//   content byte for content results (zero otherwise), m_tlast marks the final result of
//   one input byte. A byte gives zero, one or two results.
//   A byte taken in passes through the input register and the result queue before its results reach m_.
//   Throughput: one byte per cycle while the receiver keeps up; a byte that gives two
//   results leaves them on m_ one at a time, and the 4-entry result queue absorbs the burst.
//   The input register holds a byte until the queue has room for all of its results,
//   so a stalled receiver backs up into s_tready after a few requests; nothing is lost.
//   The APB port holds max_chars at address 0 (reset 63; 0 acts as 1). Write it only
//   while the stream is idle.
//   Reset: asynchronous, active low; clears the scanner to idle with a zero count,
//   empties the queue and input register, and restores max_chars.

module json_token_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	// stream in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,    // [7:0] text_byte
	// stream out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,    // [7:0] char_value
	output logic [3:0]                 m_tuser,    // [3:0] kind
	output logic                       m_tlast,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jts_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [7:0]                        byte_s1;
	logic                              valid_s1;
	jts_pkg::count_t                   max_chars_q;
	jts_pkg::count_t                   limit;
	jts_pkg::scan_out_t                res;
	logic [jts_pkg::LVL_W-1:0]         space;
	logic                              commit;
	logic                              reg_sel;

	// Configuration register
	assign pready = 1'b1;
	assign reg_sel = paddr[jts_pkg::ADDR_W-1] == jts_pkg::REG_MAX_CHARS;
	assign prdata = reg_sel ? {{(32 - jts_pkg::CNT_W){1'b0}}, max_chars_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= jts_pkg::MAX_CHARS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_chars_q <= pwdata[jts_pkg::CNT_W-1:0];
		end
	end

	// Limit in use: capped by MAX_TOKEN, zero acts as one
	always_comb begin
		limit = max_chars_q;
		if (max_chars_q > jts_pkg::count_t'(jts_pkg::MAX_TOKEN))
			limit = jts_pkg::count_t'(jts_pkg::MAX_TOKEN);
		if (limit == '0)
			limit = jts_pkg::count_t'(1);
	end

	// Input register; a byte leaves once the queue can take all of its results
	assign commit = valid_s1 && ({1'b0, res.count} <= space);
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	jts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (byte_s1),
		.commit    (commit),
		.limit     (limit),
		.res       (res)
	);

	jts_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (commit),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hw/rtl/jts_checker.sv -----
// jts_checker: port-level checks on the JSON token scanner, bound to the top level.
// Depends on jts_pkg and json_token_scanner.
`timescale 1ns / 1ps

module jts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [7:0]                 m_tdata,
	input logic [3:0]                 m_tuser,
	input logic                       m_tlast
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Only content results carry a byte
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != jts_pkg::KIND_CHAR |-> m_tdata == 8'h00)
		else $error("non-content result carries data");

	// Kind stays within the defined codes
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= jts_pkg::KIND_CHAR)
		else $error("undefined result kind");

	// End and string tokens always close the results of their byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == jts_pkg::KIND_END || m_tuser == jts_pkg::KIND_STRING)
			|-> m_tlast)
		else $error("end or string token not last");

endmodule

bind json_token_scanner jts_checker u_jts_checker (.*);

// ----- tb/jts_token_checker.sv -----
// jts_token_checker: watches the text and token streams of json_token_scanner, predicts the
// tokens of every accepted text byte and compares them with the tokens that leave the block.
// Depends on jts_pkg; instantiated by json_token_scanner_test.
`timescale 1ns / 1ps

module jts_token_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,    // [7:0] text_byte
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [7:0]                 m_tdata,    // [7:0] char_value
	input  logic [3:0]                 m_tuser,    // [3:0] kind
	input  logic                       m_tlast,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jts_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic [31:0]                prdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         pending,
	output int                         tokens_checked
);
	import jts_pkg::*;

	localparam logic [ADDR_W-1:0] MAX_CHARS_ADDR = ADDR_W'(4 * REG_MAX_CHARS);

	// Scanner copy: mode, content count and the length register
	mode_t   mode;
	count_t  count;
	count_t  max_chars;

	// Tokens of the byte being predicted, and the tokens still owed by the block
	result_t tok_buf [2];
	int      tok_n;
	result_t expected_tokens [$];
	int      errors;
	int      checked;

	function automatic logic byte_is_digit(input logic [7:0] b);
		return (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
	endfunction

	task automatic add_token(input kind_t k, input logic [7:0] ch);
		if (tok_n < 2) begin
			tok_buf[tok_n].kind = k;
			tok_buf[tok_n].char_value = (k == KIND_CHAR) ? ch : 8'h00;
			tok_buf[tok_n].last = 1'b0;
			tok_n++;
		end
	endtask

	// A byte seen from idle, or re-handled after a number closes
	task automatic open_token(input logic [7:0] b);
		case (b)
			CH_NUL: begin
				add_token(KIND_END, 8'h00);
				mode = MODE_IDLE;
			end
			CH_SPACE, CH_TAB, CH_CR, CH_LF: mode = MODE_IDLE;
			CH_LBRACE: begin
				add_token(KIND_LBRACE, 8'h00);
				mode = MODE_IDLE;
			end
			CH_RBRACE: begin
				add_token(KIND_RBRACE, 8'h00);
				mode = MODE_IDLE;
			end
			CH_LBRACK: begin
				add_token(KIND_LBRACK, 8'h00);
				mode = MODE_IDLE;
			end
			CH_RBRACK: begin
				add_token(KIND_RBRACK, 8'h00);
				mode = MODE_IDLE;
			end
			CH_COLON: begin
				add_token(KIND_COLON, 8'h00);
				mode = MODE_IDLE;
			end
			CH_COMMA: begin
				add_token(KIND_COMMA, 8'h00);
				mode = MODE_IDLE;
			end
			CH_QUOTE: begin
				mode = MODE_STR;
				count = '0;
			end
			default: begin
				if (b == CH_MINUS || byte_is_digit(b)) begin
					add_token(KIND_CHAR, b);
					count = count_t'(1);
					mode = MODE_INT;
				end else begin
					add_token(KIND_ERROR, 8'h00);
					mode = MODE_ERR;
				end
			end
		endcase
	endtask

	// Advance the scanner copy by one byte and queue the tokens it gives
	task automatic predict_tokens(input logic [7:0] b);
		int lim;
		tok_n = 0;
		lim = max_chars;
		if (lim > MAX_TOKEN) lim = MAX_TOKEN;
		if (lim < 1) lim = 1;
		case (mode)
			MODE_STR: begin
				if (b == CH_QUOTE) begin
					add_token(KIND_STRING, 8'h00);
					mode = MODE_IDLE;
				end else if (b == CH_NUL) begin
					add_token(KIND_ERROR, 8'h00);
					add_token(KIND_END, 8'h00);
					mode = MODE_IDLE;
				end else if (count >= lim) begin
					// string overflow
					add_token(KIND_ERROR, 8'h00);
					mode = MODE_ERR;
				end else if (b == CH_BSLASH) begin
					mode = MODE_ESC;
				end else begin
					add_token(KIND_CHAR, b);
					count = count + 1'b1;
				end
			end
			MODE_ESC: begin
				if (b == CH_NUL) begin
					add_token(KIND_ERROR, 8'h00);
					add_token(KIND_END, 8'h00);
					mode = MODE_IDLE;
				end else begin
					add_token(KIND_CHAR, b);
					count = count + 1'b1;
					mode = MODE_STR;
				end
			end
			MODE_INT, MODE_FRAC: begin
				if (count < lim && byte_is_digit(b)) begin
					add_token(KIND_CHAR, b);
					count = count + 1'b1;
				end else if (count < lim && mode == MODE_INT && b == CH_DOT) begin
					add_token(KIND_CHAR, b);
					count = count + 1'b1;
					mode = MODE_FRAC;
				end else begin
					// number closes; the byte starts anew
					add_token(KIND_NUMBER, 8'h00);
					mode = MODE_IDLE;
					open_token(b);
				end
			end
			MODE_ERR: begin
				if (b == CH_NUL) begin
					add_token(KIND_END, 8'h00);
					mode = MODE_IDLE;
				end
			end
			default: open_token(b);
		endcase
		if (tok_n > 0) tok_buf[tok_n-1].last = 1'b1;
		for (int i = 0; i < tok_n; i++) expected_tokens.push_back(tok_buf[i]);
	endtask

	// Register access, text requests and token requests, all seen at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			count = '0;
			max_chars = MAX_CHARS_RST;
			expected_tokens.delete();
			errors = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			tokens_checked <= 0;
		end else begin
			if (psel && penable && pready && paddr == MAX_CHARS_ADDR) begin
				if (pwrite) begin
					max_chars = pwdata[CNT_W-1:0];
				end else if (prdata !== 32'(max_chars)) begin
					$display("%0t: max_chars read mismatch, expected %0d, got %0d",
						$time, max_chars, prdata);
					errors++;
				end
			end
			if (s_tvalid && s_tready) predict_tokens(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token, expected none, got kind %0d char %02h last %0b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					result_t want;
					want = expected_tokens.pop_front();
					if (m_tuser !== want.kind) begin
						$display("%0t: kind mismatch, expected %0d, got %0d",
							$time, want.kind, m_tuser);
						errors++;
					end
					if (m_tdata !== want.char_value) begin
						$display("%0t: char_value mismatch, expected %02h, got %02h",
							$time, want.char_value, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last mismatch, expected %0b, got %0b",
							$time, want.last, m_tlast);
						errors++;
					end
				end
				checked++;
			end
			fail_count <= errors;
			pending <= expected_tokens.size();
			tokens_checked <= checked;
		end
	end

endmodule

// ----- tb/json_token_scanner_test.sv -----
// json_token_scanner_test: drives text documents and max_chars settings into json_token_scanner,
// with bursty requests and a stalling receiver; jts_token_checker judges the tokens.
// Depends on jts_pkg, json_token_scanner and jts_token_checker.
`timescale 1ns / 1ps

module json_token_scanner_test;
	import jts_pkg::*;

	localparam logic [ADDR_W-1:0] MAX_CHARS_ADDR = ADDR_W'(4 * REG_MAX_CHARS);
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASE_BYTES  = 100;
	localparam int NUM_PHASES   = 7;

	// Receiver stall styles
	localparam int RX_ALWAYS = 0;
	localparam int RX_HALF   = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_MOSTLY = 3;

	// Value shapes of the document generator
	localparam int VAL_OBJECT = 0;
	localparam int VAL_ARRAY  = 1;
	localparam int VAL_STRING = 2;
	localparam int VAL_NUMBER = 3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'h00;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic [3:0]        m_tuser;
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int                fail_count;
	int                pending;
	int                tokens_checked;
	int                cycle_count = 0;
	int                bytes_sent = 0;
	int                docs_sent = 0;
	int                burst_left = 0;
	int                limit_settings = 0;
	bit                hold_req = 1'b0;
	logic [7:0]        text_q [$];
	logic [5:0]        limit_plan [NUM_PHASES];

	json_token_scanner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	jts_token_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending),
		.tokens_checked (tokens_checked)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: changing stall styles, plus a long hold-off on request
	initial begin : receiver
		int style;
		int left;
		style = RX_ALWAYS;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				style = $urandom_range(RX_ALWAYS, RX_MOSTLY);
				left = $urandom_range(10, 150);
			end
			left--;
			case (style)
				RX_ALWAYS: m_tready = 1'b1;
				RX_HALF:   m_tready = 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
				default:   m_tready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// One text request, in bursts with random gaps between them
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 48);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text();
		while (text_q.size() != 0) send_byte(text_q.pop_front());
	endtask

	// Stop sending until every token has come, then let the block settle
	task automatic drain_tokens();
		s_tvalid = 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = MAX_CHARS_ADDR;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Write max_chars with junk in the unused bits, then read it back
	task automatic set_max_chars(input logic [5:0] v);
		apb_access(1'b1, ($urandom() & ~32'h3F) | 32'(v));
		apb_access(1'b0, $urandom());
		limit_settings++;
	endtask

	task automatic gen_ws();
		case ($urandom_range(0, 5))
			0: text_q.push_back(CH_SPACE);
			1: text_q.push_back(CH_TAB);
			2: text_q.push_back(CH_CR);
			3: text_q.push_back(CH_LF);
			default: ;
		endcase
	endtask

	task automatic gen_string();
		int len;
		logic [7:0] c;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
		text_q.push_back(CH_QUOTE);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				// escape: any nonzero byte passes through
				text_q.push_back(CH_BSLASH);
				text_q.push_back(8'($urandom_range(1, 255)));
			end else begin
				c = 8'($urandom_range(1, 255));
				while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(1, 255));
				text_q.push_back(c);
			end
		end
		text_q.push_back(CH_QUOTE);
	endtask

	task automatic gen_number();
		int digits;
		bit minus;
		minus = ($urandom_range(0, 3) == 0);
		if (minus) text_q.push_back(CH_MINUS);
		digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 4);
		if (!minus && digits == 0) digits = 1;
		for (int i = 0; i < digits; i++)
			text_q.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) == 0) begin
			text_q.push_back(CH_DOT);
			digits = $urandom_range(0, 4);
			for (int i = 0; i < digits; i++)
				text_q.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic gen_value(input int depth);
		int pick;
		int members;
		pick = (depth >= 3) ? $urandom_range(VAL_STRING, VAL_NUMBER)
			: $urandom_range(VAL_OBJECT, VAL_NUMBER);
		gen_ws();
		case (pick)
			VAL_OBJECT: begin
				text_q.push_back(CH_LBRACE);
				members = $urandom_range(0, 3);
				for (int i = 0; i < members; i++) begin
					if (i > 0) text_q.push_back(CH_COMMA);
					gen_ws();
					gen_string();
					gen_ws();
					text_q.push_back(CH_COLON);
					gen_value(depth + 1);
					gen_ws();
				end
				text_q.push_back(CH_RBRACE);
			end
			VAL_ARRAY: begin
				text_q.push_back(CH_LBRACK);
				members = $urandom_range(0, 3);
				for (int i = 0; i < members; i++) begin
					if (i > 0) text_q.push_back(CH_COMMA);
					gen_value(depth + 1);
					gen_ws();
				end
				text_q.push_back(CH_RBRACK);
			end
			VAL_STRING: gen_string();
			default: gen_number();
		endcase
	endtask

	// Mostly well-formed documents; some truncated, some with a stray byte, some pure noise
	task automatic gen_document();
		int shape;
		int n;
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			gen_value(0);
			gen_ws();
			if (shape == 1) begin
				n = $urandom_range(0, text_q.size() - 1);
				while (text_q.size() > n) void'(text_q.pop_back());
			end else if (shape == 2) begin
				text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
			end
		end
		text_q.push_back(CH_NUL);
		docs_sent++;
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed text under the reset limit: punctuation, whitespace, escapes,
		// numbers with a dot, lone minus, stray byte with error mode, end inside string
		// and after a backslash, number closed by end of text
		text_q = {CH_LBRACE, CH_QUOTE, 8'h6B, CH_BSLASH, CH_QUOTE, CH_QUOTE, CH_COLON,
			CH_MINUS, 8'h31, CH_DOT, 8'h39, CH_SPACE, CH_COMMA, CH_LBRACK, CH_MINUS,
			CH_RBRACK, CH_RBRACE, 8'hFF, 8'h71, CH_NUL, CH_QUOTE, CH_NUL, CH_QUOTE,
			CH_BSLASH, CH_NUL, CH_TAB, CH_CR, CH_LF, 8'h35, CH_NUL};
		docs_sent = 4;
		send_text();
		drain_tokens();

		// Random phases, each under its own limit: the extremes, zero, and tight ones
		limit_plan = '{6'd1, 6'd0, 6'd2, 6'd63, 6'd3, 6'd63, 6'd5};
		limit_plan[5] = 6'($urandom_range(1, 63));
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_max_chars(limit_plan[p]);
			if (p == 3) hold_req = 1'b1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				gen_document();
				send_text();
			end
			drain_tokens();
		end

		$display("Scanned %0d text bytes in %0d documents under %0d max_chars settings.",
			bytes_sent, docs_sent, limit_settings);
		$display("Compared %0d tokens, with a long receiver hold-off and drains between phases.",
			tokens_checked);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
